/* src/bba_pkg.sv */
// Shared types and constants for the block-allocation bitmap.
// Opcodes, field widths and the controller/datapath command and status structs.
// No dependencies.
package bba_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int BYTE_W   = 8;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_MARK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TEST  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_COUNT = 3'd4;

    typedef struct packed {
        logic accept;    // latch a new request
        logic scan;      // examine one bitmap byte for allocate
        logic exec;      // run a single-bit operation
        logic load_out;  // move the finished result into the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic req_is_alloc;  // incoming request is an allocate
        logic scan_done;     // free bit found or last byte examined
    } t_dp_status;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] found_index;
        logic               bit_value;
        logic [COUNT_W-1:0] used_count;
    } t_result;

endpackage

/* src/bba_req_if.sv */
// Request channel of the block-allocation bitmap: valid/ready plus request fields.
// Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

/* src/bba_rsp_if.sv */
// Response channel of the block-allocation bitmap: valid/ready plus result fields.
// Depends on bba_pkg.
interface bba_rsp_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [INDEX_W-1:0] found_index;
    logic               bit_value;
    logic [COUNT_W-1:0] used_count;

    modport source (output valid, output ok, output found_index, output bit_value,
                    output used_count, input ready);
    modport sink   (input valid, input ok, input found_index, input bit_value,
                    input used_count, output ready);
endinterface

/* src/bitmap_block_allocator.sv */
// Block-allocation bitmap with a request channel and a response channel.
//
// i_req carries opcode and block_index; o_rsp returns ok, found_index,
// bit_value and used_count, one response per request, in request order.
// Opcodes: allocate lowest free block, mark used, free, test, count used.
// A request is taken only while the controller is idle; one item is in
// flight at a time. Allocate walks the bitmap one byte per cycle, stopping
// at the first byte with a free bit or at the last byte; every other
// opcode goes through the execute state. The response appears in the output
// register in the same cycle that the controller is ready again.
// The output register holds a response while o_rsp.ready is low; the next
// request is still accepted and worked on, and its result waits in the
// datapath until the output register is free.
// Reset (synchronous, active low) marks every block free, clears the
// used count and holds i_req.ready low; no clearing pass is needed.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ctrl, bba_dp.
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_result    rsp;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_req.opcode),
        .i_block_index (i_req.block_index),
        .o_status      (status),
        .o_rsp         (rsp)
    );

    assign o_rsp.ok          = rsp.ok;
    assign o_rsp.found_index = rsp.found_index;
    assign o_rsp.bit_value   = rsp.bit_value;
    assign o_rsp.used_count  = rsp.used_count;

endmodule

/* src/bba_ctrl.sv */
// Controller of the block-allocation bitmap: sequences accept, scan/exec and output load.
// Depends on bba_pkg.
module bba_ctrl import bba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_rsp_ready,
    input  t_dp_status i_status,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_rsp_ready;
    // hold off requests while reset is asserted
    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        o_cmd.accept   = o_req_ready && i_req_valid;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_status.req_is_alloc ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // hold the result until taken, load a new one when it is ready
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/bba_dp.sv */
// Datapath of the block-allocation bitmap: bitmap bytes, running count, scan pointer
// and result registers. Depends on bba_pkg.
module bba_dp import bba_pkg::*; #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_block_index,
    output t_dp_status          o_status,
    output t_result             o_rsp
);

    localparam int LIMIT = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int ROWS  = (LIMIT + BYTE_W - 1) / BYTE_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [BYTE_W-1:0]   r_map [ROWS];
    logic [COUNT_W-1:0]  r_used, n_used;
    logic [OPCODE_W-1:0] r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic [ROW_W-1:0]    r_ptr;
    t_result             r_res, n_res;
    t_result             r_out;

    logic               wr_en;
    logic [ROW_W-1:0]   wr_row;
    logic [2:0]         wr_bit;
    logic               wr_val;

    logic [BYTE_W-1:0]  scan_row;
    logic [BYTE_W-1:0]  scan_free;
    logic [2:0]         scan_pos;
    logic               scan_hit;
    logic               scan_last;

    logic               in_range;
    logic [ROW_W-1:0]   exec_row;
    logic               exec_bit;

    // bits of a byte that lie below the addressable limit
    function automatic logic [BYTE_W-1:0] row_mask(input logic [ROW_W-1:0] row);
        logic [BYTE_W-1:0] m;
        logic [8:0]        blk;
        for (int j = 0; j < BYTE_W; j++) begin
            blk  = 9'({row, 3'(j)});
            m[j] = (blk < 9'(LIMIT));
        end
        return m;
    endfunction

    assign scan_row  = r_map[r_ptr];
    assign scan_free = ~scan_row & row_mask(r_ptr);
    assign scan_hit  = |scan_free;
    assign scan_last = (r_ptr == ROW_W'(ROWS - 1));

    always_comb begin
        scan_pos = 3'd0;
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            if (scan_free[j]) begin
                scan_pos = 3'(j);
            end
        end
    end

    assign in_range = ({1'b0, r_idx} < 9'(LIMIT));
    assign exec_row = ROW_W'(r_idx[INDEX_W-1:3]);
    assign exec_bit = in_range ? r_map[exec_row][r_idx[2:0]] : 1'b0;

    assign o_status.req_is_alloc = (i_opcode == OP_ALLOC);
    assign o_status.scan_done    = scan_hit || scan_last;

    always_comb begin
        wr_en  = 1'b0;
        wr_row = r_ptr;
        wr_bit = scan_pos;
        wr_val = 1'b1;
        n_used = r_used;
        n_res  = r_res;

        if (i_cmd.scan) begin
            if (scan_hit) begin
                wr_en             = 1'b1;
                n_used            = r_used + 9'd1;
                n_res.ok          = 1'b1;
                n_res.found_index = INDEX_W'({r_ptr, scan_pos});
                n_res.bit_value   = 1'b0;
                n_res.used_count  = r_used + 9'd1;
            end else if (scan_last) begin
                // map full: leave state alone
                n_res.ok          = 1'b0;
                n_res.found_index = '0;
                n_res.bit_value   = 1'b0;
                n_res.used_count  = r_used;
            end
        end else if (i_cmd.exec) begin
            wr_row            = exec_row;
            wr_bit            = r_idx[2:0];
            n_res.ok          = 1'b0;
            n_res.found_index = r_idx;
            n_res.bit_value   = 1'b0;
            if (r_op == OP_COUNT) begin
                n_res.ok = 1'b1;
            end else if (in_range && (r_op == OP_MARK || r_op == OP_FREE
                                      || r_op == OP_TEST)) begin
                n_res.ok        = 1'b1;
                n_res.bit_value = exec_bit;
                if (r_op == OP_MARK && !exec_bit) begin
                    wr_en  = 1'b1;
                    wr_val = 1'b1;
                    n_used = r_used + 9'd1;
                end else if (r_op == OP_FREE && exec_bit) begin
                    wr_en  = 1'b1;
                    wr_val = 1'b0;
                    n_used = r_used - 9'd1;
                end
            end
            n_res.used_count = n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_map[r] <= '0;
            end
            r_used <= '0;
        end else begin
            if (wr_en) begin
                r_map[wr_row][wr_bit] <= wr_val;
            end
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_idx <= i_block_index;
            r_ptr <= '0;
        end else if (i_cmd.scan) begin
            r_ptr <= r_ptr + ROW_W'(1);
        end
        r_res <= n_res;
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_rsp = r_out;

endmodule

/* tb/tb_bitmap_block_allocator.sv */
// Self-checking testbench for bitmap_block_allocator: directed cases, a full-map pass,
// output back-pressure and a long random run, all checked against an in-bench bitmap.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and the bitmap_block_allocator RTL.
module tb_bitmap_block_allocator import bba_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS    = 256;
    localparam int ADDR_LIMIT    = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int RANDOM_ITEMS  = 650;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;

    // opcodes the block does not define
    localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();

    bitmap_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // expected block state and the responses still owed
    logic [255:0]        blk_used;
    logic [COUNT_W-1:0]  blk_used_total;
    t_result             owed_results[$];

    int  fails;
    bit  sender_idles;
    bit  receiver_idles;
    int  hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_200_000;
        $display("bitmap_block_allocator test failed");
        $finish;
    end

    // Apply one request to the expected bitmap and return the response it must produce.
    function automatic t_result bitmap_apply(logic [OPCODE_W-1:0] op,
                                             logic [INDEX_W-1:0] idx);
        t_result r;
        bit      hit;
        r.ok          = 1'b0;
        r.found_index = idx;
        r.bit_value   = 1'b0;
        hit           = 1'b0;
        case (op)
            OP_ALLOC: begin
                r.found_index = '0;
                for (int i = 0; i < ADDR_LIMIT && !hit; i++) begin
                    if (!blk_used[i]) begin
                        blk_used[i]    = 1'b1;
                        blk_used_total = blk_used_total + 1'b1;
                        r.found_index  = INDEX_W'(i);
                        r.ok           = 1'b1;
                        hit            = 1'b1;
                    end
                end
            end
            OP_MARK, OP_FREE, OP_TEST: begin
                if (idx < ADDR_LIMIT) begin
                    r.ok        = 1'b1;
                    r.bit_value = blk_used[idx];
                    if (op == OP_MARK && !r.bit_value) begin
                        blk_used[idx]  = 1'b1;
                        blk_used_total = blk_used_total + 1'b1;
                    end else if (op == OP_FREE && r.bit_value) begin
                        blk_used[idx]  = 1'b0;
                        blk_used_total = blk_used_total - 1'b1;
                    end
                end
            end
            OP_COUNT: r.ok = 1'b1;
            default: ;
        endcase
        r.used_count = blk_used_total;
        return r;
    endfunction

    // Offer one item, wait for the handshake, then record what must come back.
    // Valid stays high afterwards so back-to-back items need no second assignment.
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx);
        int gap;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.block_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        owed_results.push_back(bitmap_apply(op, idx));
    endtask

    // Drop valid so the last item is not offered again, then drain.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: a random stall before each item, plus any long hold the tests request.
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 7) : 0;
            stall = stall + hold_request;
            hold_request = 0;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid && hold_request == 0) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (owed_results.size() == 0) begin
                $error("response item with nothing outstanding");
                fails++;
            end else begin
                want = owed_results.pop_front();
                if (rsp_if.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
                    fails++;
                end
                if (rsp_if.found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, rsp_if.found_index);
                    fails++;
                end
                if (rsp_if.bit_value !== want.bit_value) begin
                    $error("bit_value: expected %0d, got %0d",
                           want.bit_value, rsp_if.bit_value);
                    fails++;
                end
                if (rsp_if.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, rsp_if.used_count);
                    fails++;
                end
            end
        end
    end

    // Every opcode, both index extremes, repeated mark and free, reserved codes.
    task automatic test_directed();
        send_request(OP_COUNT, 8'h00);
        send_request(OP_ALLOC, 8'hFF);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'hA5);
        send_request(OP_TEST,  8'h00);
        send_request(OP_TEST,  8'hFF);
        send_request(OP_MARK,  8'hFF);
        send_request(OP_MARK,  8'hFF);
        send_request(OP_TEST,  8'hFF);
        send_request(OP_FREE,  8'h01);
        send_request(OP_FREE,  8'h01);
        send_request(OP_ALLOC, 8'h5A);
        send_request(OP_COUNT, 8'hFF);
        send_request(OP_FREE,  8'hFF);
        send_request(OP_TEST,  8'hFF);
        send_request(OP_RSVD5, 8'hAA);
        send_request(OP_RSVD6, 8'h55);
        send_request(OP_RSVD7, 8'hFF);
        send_request(OP_MARK,  8'h00);
        send_request(OP_FREE,  8'h00);
        send_request(OP_TEST,  8'h00);
        send_request(OP_MARK,  8'h80);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_COUNT, 8'h7F);
    endtask

    // Fill the whole map, hit allocate on a full map, then reopen holes and allocate into them.
    task automatic test_full_map();
        while (blk_used_total < ADDR_LIMIT) send_request(OP_ALLOC, INDEX_W'($urandom()));
        send_request(OP_ALLOC, 8'hFF);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_MARK,  8'hFF);
        send_request(OP_TEST,  8'h00);
        send_request(OP_COUNT, 8'h3C);
        send_request(OP_FREE,  8'd137);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_FREE,  8'hFF);
        send_request(OP_FREE,  8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h00);
    endtask

    // Hold the receiver off while the sender keeps offering items back to back.
    task automatic test_pressure();
        wait_idle();
        sender_idles = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (12) send_request(OP_FREE, INDEX_W'($urandom()));
        sender_idles = 1'b1;
    endtask

    // Phases biased toward filling, draining or a balance, with noise mixed in.
    task automatic test_random();
        int                  sent;
        int                  roll;
        int                  alloc_lim;
        int                  free_lim;
        int                  start;
        t_mix                mix;
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix            = t_mix'($urandom_range(0, 2));
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            case (mix)
                MIX_FILL:  begin alloc_lim = 78; free_lim = 82; end
                MIX_DRAIN: begin alloc_lim = 20; free_lim = 68; end
                default:   begin alloc_lim = 42; free_lim = 62; end
            endcase
            repeat (100) begin
                roll = $urandom_range(0, 99);
                idx  = INDEX_W'($urandom());
                if (roll < 8) begin
                    op = OPCODE_W'($urandom());
                end else if (roll < alloc_lim) begin
                    op = OP_ALLOC;
                end else if (roll < free_lim) begin
                    op = OP_FREE;
                    // mostly aim at a block that is in use
                    if ($urandom_range(0, 3) != 0) begin
                        start = $urandom_range(0, ADDR_LIMIT - 1);
                        for (int k = 0; k < ADDR_LIMIT; k++) begin
                            if (blk_used[(start + k) % ADDR_LIMIT]) begin
                                idx = INDEX_W'((start + k) % ADDR_LIMIT);
                                break;
                            end
                        end
                    end
                end else if (roll < 84) begin
                    op = OP_MARK;
                end else if (roll < 94) begin
                    op = OP_TEST;
                end else begin
                    op = OP_COUNT;
                end
                send_request(op, idx);
                sent++;
            end
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial begin
        fails              = 0;
        hold_request       = 0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        blk_used           = '0;
        blk_used_total     = '0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.opcode      <= OP_ALLOC;
        req_if.block_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_map();
        test_pressure();
        test_random();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("bitmap_block_allocator test passed");
        end else begin
            $display("bitmap_block_allocator test failed");
        end
        $finish;
    end

endmodule
